/* design/pfp_pkg.sv */
// Shared types and constants for the PCM frame packer with peak meter.
package pfp_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int SAMPLE_FIELDS = 4;
  localparam int NUM_LANES = (MAX_CHANNELS < SAMPLE_FIELDS) ? MAX_CHANNELS : SAMPLE_FIELDS;
  localparam int BUF_BYTES = NUM_LANES * 4;
  localparam int BYTE_IDX_W = $clog2(BUF_BYTES);
  localparam int CNT_W = $clog2(BUF_BYTES + 1);

  // configuration register indexes
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_SUBFRAME_BYTES = 2'd1;
  localparam logic [1:0] REG_CLIP_ENABLE = 2'd2;

  // subframe sizes in bytes
  localparam logic [2:0] SUB_2B = 3'd2;
  localparam logic [2:0] SUB_3B = 3'd3;
  localparam logic [2:0] SUB_4B = 3'd4;

  localparam logic [2:0] NCH_MIN = 3'd1;
  localparam logic [2:0] NCH_MAX = 3'(NUM_LANES);

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_PEAK = 1'b1;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_PEAK = 1'b1;

  typedef logic [NUM_LANES-1:0][31:0] lane_word_t;

  // per-item control that travels with the lane registers into the merge stage
  typedef struct packed {
    logic             peak_req;
    logic [2:0]       nch;
    logic [2:0]       sb;
    logic [CNT_W-1:0] nbytes;
    logic             clip_en;
  } ctl_t;

endpackage

/* design/pfp_lane.sv */
// One channel lane: Q1.31 sample scaling to PCM word and magnitude for the peak meter.
module pfp_lane (
  input  logic               clk,
  input  logic               en,
  input  logic               sel16,
  input  logic signed [31:0] sample,
  output logic [31:0]        word,
  output logic [31:0]        mag
);
  import pfp_pkg::*;

  logic signed [63:0] s64;
  logic signed [63:0] prod_nxt;
  logic signed [63:0] prod_r;
  logic [31:0]        mag_nxt;
  logic [31:0]        mag_r;
  logic signed [63:0] quo;
  logic               fix;

  // gain of 2^k - 1 is a shift and a subtract
  assign s64 = {{32{sample[31]}}, sample};
  assign prod_nxt = sel16 ? ((s64 <<< 15) - s64) : ((s64 <<< 31) - s64);
  assign mag_nxt = sample[31] ? (~sample + 32'd1) : sample;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      mag_r  <= mag_nxt;
    end
  end

  // divide by 2^31 toward zero: arithmetic shift, bump negatives with a remainder
  assign quo = prod_r >>> 31;
  assign fix = prod_r[63] & (|prod_r[30:0]);
  assign word = quo[31:0] + {31'd0, fix};
  assign mag = mag_r;

endmodule

/* design/pfp_merge.sv */
// Merge stage: packs lane words into the byte stream, tracks the peak, serializes output.
module pfp_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  pfp_pkg::ctl_t        ctl,
  input  pfp_pkg::lane_word_t  words,
  input  pfp_pkg::lane_word_t  mags,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_result_kind,
  output logic [7:0]           out_byte,
  output logic                 out_last,
  output logic [31:0]          out_peak_value
);
  import pfp_pkg::*;

  logic [BUF_BYTES-1:0][7:0] buf_r, buf_nxt;
  logic [BUF_BYTES-1:0][7:0] packed_bytes;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      kind_r, kind_nxt;
  logic [31:0]               rpt_r, rpt_nxt;
  logic [31:0]               peak_r, peak_nxt;
  logic [31:0]               peak_upd;
  lane_word_t                wadj;
  logic                      out_fire;

  assign out_valid = (cnt_r != '0);
  assign out_fire = out_valid & out_ready;
  assign free = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ready);

  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      wadj[c] = (ctl.sb == SUB_3B) ? (words[c] >> 8) : words[c];
    end
    packed_bytes = '0;
    case (ctl.sb)
      SUB_2B: begin
        for (int c = 0; c < NUM_LANES; c++) begin
          for (int b = 0; b < 2; b++) begin
            packed_bytes[BYTE_IDX_W'(c * 2 + b)] = wadj[c][8 * b +: 8];
          end
        end
      end
      SUB_3B: begin
        for (int c = 0; c < NUM_LANES; c++) begin
          for (int b = 0; b < 3; b++) begin
            packed_bytes[BYTE_IDX_W'(c * 3 + b)] = wadj[c][8 * b +: 8];
          end
        end
      end
      default: begin
        for (int c = 0; c < NUM_LANES; c++) begin
          for (int b = 0; b < 4; b++) begin
            packed_bytes[BYTE_IDX_W'(c * 4 + b)] = wadj[c][8 * b +: 8];
          end
        end
      end
    endcase
  end

  // ch1 joins the meter only when the frame has two or more channels
  always_comb begin
    peak_upd = peak_r;
    if (mags[0] >= peak_upd) peak_upd = mags[0];
    if ((ctl.nch >= 3'd2) && (mags[1] >= peak_upd)) peak_upd = mags[1];
  end

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    kind_nxt = kind_r;
    rpt_nxt = rpt_r;
    peak_nxt = peak_r;
    if (load) begin
      if (ctl.peak_req == REQ_PEAK) begin
        buf_nxt = '0;
        cnt_nxt = CNT_W'(1);
        kind_nxt = KIND_PEAK;
        rpt_nxt = peak_r;
        peak_nxt = '0;
      end else begin
        buf_nxt = packed_bytes;
        cnt_nxt = ctl.nbytes;
        kind_nxt = KIND_BYTE;
        rpt_nxt = '0;
        if (ctl.clip_en) peak_nxt = peak_upd;
      end
    end else if (out_fire) begin
      buf_nxt = buf_r >> 8;
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      peak_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      peak_r <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    kind_r <= kind_nxt;
    rpt_r  <= rpt_nxt;
  end

  assign out_result_kind = kind_r;
  assign out_byte = buf_r[0];
  assign out_last = (cnt_r == CNT_W'(1));
  assign out_peak_value = rpt_r;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free) else $error("merge loaded while output busy");

  a_peak_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (load && ctl.peak_req == REQ_PEAK) |=> (peak_r == 32'd0))
    else $error("peak not cleared after report");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !(load && ctl.peak_req == REQ_PEAK) |=> (peak_r >= $past(peak_r)))
    else $error("peak dropped without a read");

  a_report_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && kind_r == KIND_PEAK) |-> (cnt_r == CNT_W'(1)))
    else $error("peak report spans more than one item");

endmodule

/* design/pcm_frame_packer_peak.sv */
// Top level: PCM frame packer with peak meter, four parallel lanes and a merge stage.
//
//  port group | dir | handshake            | payload
//  in_*       | in  | in_valid / in_ready  | req_type, four Q1.31 samples
//  out_*      | out | out_valid / out_ready| result_kind, byte, last, peak_value
//  cfg_*      | in  | cfg_we               | cfg_index, cfg_wdata
//
// A frame yields channel_count * subframe_bytes items, one per cycle from the
// output shift register while out_ready is high; a peak read yields one. An item
// passes the lane register, then the merge buffer. The next item is accepted while
// the current one drains and loads as its last byte leaves.
// Reset (synchronous, rst_n low) clears config to defaults, pipeline valids and peak.
// A stalled output holds its byte; the lane register holds one further item.
module pcm_frame_packer_peak (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [31:0] in_sample_ch0,
  input  logic [31:0] in_sample_ch1,
  input  logic [31:0] in_sample_ch2,
  input  logic [31:0] in_sample_ch3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [31:0] out_peak_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_wdata
);
  import pfp_pkg::*;

  logic [2:0]         nch_cfg_r, sb_cfg_r;
  logic               clip_cfg_r;
  logic               s1_valid_r, s1_valid_nxt;
  ctl_t               ctl_r, ctl_nxt;
  logic [2:0]         nch_cl, sb_cl;
  logic [5:0]         nbytes_full;
  logic               in_fire, load, free;
  logic signed [31:0] samp [SAMPLE_FIELDS];
  lane_word_t         words, mags;

  assign samp[0] = in_sample_ch0;
  assign samp[1] = in_sample_ch1;
  assign samp[2] = in_sample_ch2;
  assign samp[3] = in_sample_ch3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nch_cfg_r  <= 3'd2;
      sb_cfg_r   <= SUB_2B;
      clip_cfg_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_COUNT:  nch_cfg_r  <= cfg_wdata;
        REG_SUBFRAME_BYTES: sb_cfg_r   <= cfg_wdata;
        REG_CLIP_ENABLE:    clip_cfg_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nch_cl = nch_cfg_r;
    if (nch_cfg_r < NCH_MIN) nch_cl = NCH_MIN;
    if (nch_cfg_r > NCH_MAX) nch_cl = NCH_MAX;
    sb_cl = sb_cfg_r;
    if (sb_cfg_r < SUB_2B) sb_cl = SUB_2B;
    if (sb_cfg_r > SUB_4B) sb_cl = SUB_4B;
  end

  assign nbytes_full = 6'(nch_cl) * 6'(sb_cl);

  always_comb begin
    ctl_nxt.peak_req = in_req_type;
    ctl_nxt.nch = nch_cl;
    ctl_nxt.sb = sb_cl;
    ctl_nxt.nbytes = nbytes_full[CNT_W-1:0];
    ctl_nxt.clip_en = clip_cfg_r;
  end

  assign in_ready = !s1_valid_r || free;
  assign in_fire = in_valid & in_ready;
  assign load = s1_valid_r & free;
  assign s1_valid_nxt = in_fire ? 1'b1 : (load ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ctl_r <= ctl_nxt;
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    pfp_lane u_lane (
      .clk    (clk),
      .en     (in_fire),
      .sel16  (sb_cl == SUB_2B),
      .sample (samp[g]),
      .word   (words[g]),
      .mag    (mags[g])
    );
  end

  pfp_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .ctl             (ctl_r),
    .words           (words),
    .mags            (mags),
    .free            (free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_peak_value  (out_peak_value)
  );

endmodule
